### rtl/salc_pkg.sv
// ----------------------------------------------------------------------------
// salc_pkg
// Shared types and constants of the set-associative lookup unit.
// ----------------------------------------------------------------------------
package salc_pkg;

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned CNT_W      = 32;
  localparam int unsigned WAY_OUT_W  = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 3;
  localparam int unsigned FIELD_MAX  = 6;
  localparam int unsigned RAW_SET_W  = 6;
  localparam int unsigned RAW_SETS   = 64;
  localparam int unsigned OUT_BITS   = 1 + WAY_OUT_W + ADDR_W + 2 * CNT_W;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

  localparam logic [CFG_DATA_W-1:0] OFFSET_BITS_RST = 3'd2;
  localparam logic [CFG_DATA_W-1:0] INDEX_BITS_RST  = 3'd6;
  localparam logic [CFG_DATA_W-1:0] WAYS_IN_USE_RST = 3'd4;

  // controller to datapath
  typedef struct packed {
    logic clr;  // write one reset row
    logic rd;   // read the set row of the incoming word
    logic upd;  // write back the row and load the result
  } salc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;  // last row of the clearing pass
    logic out_free;  // result register can take a word
  } salc_stat_t;

endpackage

### rtl/salc_ctrl.sv
// ----------------------------------------------------------------------------
// salc_ctrl
// Sequencer: clearing pass after reset, then read / update per address.
// ----------------------------------------------------------------------------
module salc_ctrl
  import salc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  salc_stat_t stat_i,
  output salc_cmd_t  cmd_o
);

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_UPDATE = 2'd2;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.rd = 1'b1;
          state_d  = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        // hold the row until the result register frees up
        if (stat_i.out_free) begin
          cmd_o.upd = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

### rtl/salc_dpath.sv
// ----------------------------------------------------------------------------
// salc_dpath
// Set memory, tag compare, LRU reorder, counters and result register.
// ----------------------------------------------------------------------------
module salc_dpath
  import salc_pkg::*;
#(
  parameter int unsigned NUM_WAYS  = 4,
  parameter int unsigned SET_COUNT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  salc_cmd_t             cmd_i,
  output salc_stat_t            stat_o,
  input  logic [ADDR_W-1:0]     addr_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [OUT_DATA_W-1:0] out_data_o
);

  localparam int unsigned WAY_W  = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
  localparam int unsigned WCNT_W = $clog2(NUM_WAYS + 1);
  localparam int unsigned SET_W  = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int unsigned TAG_LSB = 1;
  localparam int unsigned ORD_LSB = 1 + ADDR_W;
  localparam int unsigned ENT_W   = 1 + ADDR_W + WAY_W;

  typedef logic [NUM_WAYS-1:0][ENT_W-1:0] row_t;

  // configuration
  logic [CFG_DATA_W-1:0] offset_bits_q, index_bits_q, ways_in_use_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_bits_q <= OFFSET_BITS_RST;
      index_bits_q  <= INDEX_BITS_RST;
      ways_in_use_q <= WAYS_IN_USE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_OFFSET_BITS: offset_bits_q <= cfg_data_i;
        CFG_INDEX_BITS:  index_bits_q  <= cfg_data_i;
        CFG_WAYS_IN_USE: ways_in_use_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [2:0]        ob, ib;
  logic [WCNT_W-1:0] ways_eff;

  always_comb begin
    ob = (32'(offset_bits_q) > FIELD_MAX) ? 3'(FIELD_MAX) : offset_bits_q;
    ib = (32'(index_bits_q) > FIELD_MAX) ? 3'(FIELD_MAX) : index_bits_q;
    if (32'(ways_in_use_q) > NUM_WAYS) begin
      ways_eff = WCNT_W'(NUM_WAYS);
    end else if (ways_in_use_q == '0) begin
      ways_eff = WCNT_W'(1);
    end else begin
      ways_eff = WCNT_W'(ways_in_use_q);
    end
  end

  // set index reduced into the sets present
  logic [SET_W-1:0] set_lut [RAW_SETS];

  for (genvar g = 0; g < RAW_SETS; g++) begin : g_set_lut
    assign set_lut[g] = SET_W'(g % SET_COUNT);
  end

  logic [RAW_SET_W-1:0] raw_set;
  logic [SET_W-1:0]     set_in;

  always_comb begin
    raw_set = RAW_SET_W'(addr_i >> ob) & RAW_SET_W'((7'd1 << ib) - 7'd1);
    set_in  = set_lut[raw_set];
  end

  // clearing pass
  logic [SET_W-1:0] clr_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr) begin
      clr_cnt_q <= clr_cnt_q + SET_W'(1);
    end
  end

  row_t clr_row;

  always_comb begin
    clr_row = '0;
    for (int r = 0; r < NUM_WAYS; r++) begin
      clr_row[r][ORD_LSB +: WAY_W] = WAY_W'(r);
    end
  end

  // set memory
  row_t             set_mem [SET_COUNT];
  row_t             row_q;
  row_t             row_new;
  logic [SET_W-1:0] set_q;
  logic [ADDR_W-1:0] addr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      set_mem[clr_cnt_q] <= clr_row;
    end else if (cmd_i.upd) begin
      set_mem[set_q] <= row_new;
    end
    if (cmd_i.rd) begin
      row_q  <= set_mem[set_in];
      set_q  <= set_in;
      addr_q <= addr_i;
    end
  end

  // lookup and reorder
  logic [ADDR_W-1:0]   tag;
  logic [WAY_W-1:0]    ord     [NUM_WAYS];
  logic [NUM_WAYS-1:0] match, free;
  logic                hit;
  logic [WAY_W-1:0]    hit_rank, vic_rank, sel_rank, way_sel;

  always_comb begin
    tag = addr_q >> (4'(ob) + 4'(ib));
    for (int r = 0; r < NUM_WAYS; r++) begin
      ord[r]   = row_q[r][ORD_LSB +: WAY_W];
      match[r] = (WCNT_W'(r) < ways_eff) && row_q[ord[r]][0] &&
                 (row_q[ord[r]][TAG_LSB +: ADDR_W] == tag);
      free[r]  = (WCNT_W'(r) < ways_eff) && !row_q[ord[r]][0];
    end
    hit = |match;
    hit_rank = '0;
    for (int r = NUM_WAYS - 1; r >= 0; r--) begin
      if (match[r]) hit_rank = WAY_W'(r);
    end
    // least recent invalid line, else the last searched rank
    vic_rank = WAY_W'(ways_eff - WCNT_W'(1));
    for (int r = 0; r < NUM_WAYS; r++) begin
      if (free[r]) vic_rank = WAY_W'(r);
    end
    sel_rank = hit ? hit_rank : vic_rank;
    way_sel  = ord[sel_rank];

    row_new = row_q;
    row_new[0][ORD_LSB +: WAY_W] = way_sel;
    for (int r = 1; r < NUM_WAYS; r++) begin
      if (WAY_W'(r) <= sel_rank) begin
        row_new[r][ORD_LSB +: WAY_W] = ord[r-1];
      end
    end
    if (!hit) begin
      row_new[way_sel][0]                = 1'b1;
      row_new[way_sel][TAG_LSB +: ADDR_W] = tag;
    end
  end

  // counters and result register
  logic [CNT_W-1:0]  acc_q, miss_q, acc_d, miss_d;
  logic [ADDR_W-1:0] fill_addr;
  logic              out_valid_q;
  logic [OUT_DATA_W-1:0] out_data_q;

  always_comb begin
    acc_d     = acc_q + CNT_W'(1);
    miss_d    = miss_q + CNT_W'(!hit);
    fill_addr = addr_q & ~((ADDR_W'(1) << ob) - ADDR_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      miss_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        acc_q       <= acc_d;
        miss_q      <= miss_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.upd) begin
      out_data_q <= OUT_DATA_W'({miss_d, acc_d, fill_addr, WAY_OUT_W'(way_sel), hit});
    end
  end

  assign stat_o.clr_last = (clr_cnt_q == SET_W'(SET_COUNT - 1));
  assign stat_o.out_free = !out_valid_q || out_ready_i;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_data_q;

endmodule

### rtl/set_assoc_lru_cache_lookup_unit.sv
// ----------------------------------------------------------------------------
// set_assoc_lru_cache_lookup_unit
// Tag lookup of a set-associative cache with LRU replacement and counters.
//
//   channel   dir  handshake                   payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata[31:0] address
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata: hit, way, fill_address,
//                                               access_total, miss_total
//   cfg       in   cfg_valid_i/cfg_ready_o      cfg_index_i, cfg_data_i
//
// Each word is first read as a set row (tags, valid bits, recency order)
// from the set memory, then compared, reordered and written back.
// After reset a clearing pass writes every set row; s_axis_tready stays low.
// A stalled result holds the update; configuration writes are always taken.
// ----------------------------------------------------------------------------
module set_assoc_lru_cache_lookup_unit
  import salc_pkg::*;
#(
  parameter int unsigned NUM_WAYS  = 4,
  parameter int unsigned SET_COUNT = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [ADDR_W-1:0]     s_axis_tdata,  // [31:0] address
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] hit, [2:1] way, [34:3] fill_address, [66:35] access_total,
  // [98:67] miss_total, [103:99] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  salc_cmd_t  cmd;
  salc_stat_t stat;

  assign cfg_ready_o = 1'b1;

  salc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  salc_dpath #(
    .NUM_WAYS  (NUM_WAYS),
    .SET_COUNT (SET_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .addr_i      (s_axis_tdata),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

  a_upd_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd |-> stat.out_free)
    else $error("update while result register is full");

  a_no_clear_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr |-> !s_axis_tready && !cmd.upd)
    else $error("lookup during clearing pass");

  a_accept_then_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second word accepted before update");

  a_upd_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.upd |=> m_axis_tvalid)
    else $error("update without result");

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the set-associative LRU lookup unit. It streams
// byte addresses in and rebuilds each lookup on its own copy of the tags,
// valid bits, recency order and counters. Every result word is checked
// field by field against that prediction. It steps through several register
// settings, including out-of-range ones, and idles and stalls both streams
// at random.
// ----------------------------------------------------------------------------
module testbench;
  import salc_pkg::*;

  localparam int unsigned WAYS           = 4;
  localparam int unsigned SETS           = RAW_SETS;
  localparam int unsigned TIMEOUT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES  = 4;
  localparam int unsigned DRAIN_CYCLES   = 16;
  localparam int unsigned RANDOM_PHASES  = 10;
  localparam int unsigned PHASE_WORDS    = 55;
  // index with no register behind it; writes to it must change nothing
  localparam logic [CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // hit lands in bit 0, matching the m_axis tdata layout
  typedef struct packed {
    logic [CNT_W-1:0]     miss_total;
    logic [CNT_W-1:0]     access_total;
    logic [ADDR_W-1:0]    fill_address;
    logic [WAY_OUT_W-1:0] way;
    logic                 hit;
  } lookup_result_t;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [ADDR_W-1:0]     s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  set_assoc_lru_cache_lookup_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // shadow of the lookup state
  logic [CFG_DATA_W-1:0] offset_reg = OFFSET_BITS_RST;
  logic [CFG_DATA_W-1:0] index_reg  = INDEX_BITS_RST;
  logic [CFG_DATA_W-1:0] ways_reg   = WAYS_IN_USE_RST;
  logic                  line_vld   [SETS][WAYS];
  logic [ADDR_W-1:0]     line_tag   [SETS][WAYS];
  logic [1:0]            rank_way   [SETS][WAYS];
  logic [CNT_W-1:0]      access_cnt = '0;
  logic [CNT_W-1:0]      miss_cnt   = '0;

  logic [ADDR_W-1:0] addr_queue[$];
  lookup_result_t    pending_results[$];
  int unsigned       mismatches = 0;
  int unsigned       cycle_cnt  = 0;
  int unsigned       send_gap   = 0;
  int unsigned       stall_left = 0;
  bit                no_idle    = 1'b0;

  function automatic int unsigned idle_len();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 65) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic lookup_result_t predict_lookup(logic [ADDR_W-1:0] addr);
    int unsigned    ob, ib, nways, set_no, rank, k;
    logic [ADDR_W-1:0] tag;
    logic [1:0]     w;
    bit             hit, found;
    lookup_result_t res;
    ob     = (offset_reg > FIELD_MAX) ? FIELD_MAX : offset_reg;
    ib     = (index_reg > FIELD_MAX) ? FIELD_MAX : index_reg;
    nways  = (ways_reg == 0) ? 1 : ((ways_reg > WAYS) ? WAYS : ways_reg);
    set_no = ((addr >> ob) & ((32'd1 << ib) - 32'd1)) % SETS;
    tag    = addr >> (ob + ib);
    hit    = 1'b0;
    found  = 1'b0;
    rank   = 0;
    for (k = 0; k < nways; k++) begin
      w = rank_way[set_no][k];
      if (!hit && line_vld[set_no][w] && line_tag[set_no][w] == tag) begin
        hit  = 1'b1;
        rank = k;
      end
    end
    if (!hit) begin
      miss_cnt = miss_cnt + 1;
      // take the least recent invalid line, else the last searched rank
      rank = nways - 1;
      for (k = nways; k > 0; k--) begin
        w = rank_way[set_no][k-1];
        if (!found && !line_vld[set_no][w]) begin
          rank  = k - 1;
          found = 1'b1;
        end
      end
    end
    w = rank_way[set_no][rank];
    for (k = rank; k > 0; k--) rank_way[set_no][k] = rank_way[set_no][k-1];
    rank_way[set_no][0] = w;
    if (!hit) begin
      line_tag[set_no][w] = tag;
      line_vld[set_no][w] = 1'b1;
    end
    access_cnt       = access_cnt + 1;
    res.hit          = hit;
    res.way          = w;
    res.fill_address = addr & ~((32'd1 << ob) - 32'd1);
    res.access_total = access_cnt;
    res.miss_total   = miss_cnt;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    $display("mismatch at cycle %0d: %s got 0x%08h want 0x%08h",
             cycle_cnt, what, got, want);
    mismatches++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_OFFSET_BITS: offset_reg = data;
      CFG_INDEX_BITS:  index_reg  = data;
      CFG_WAYS_IN_USE: ways_reg   = data;
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    do @(posedge clk_i);
    while (addr_queue.size() != 0 || s_axis_tvalid || pending_results.size() != 0);
    // let the last write-back settle before touching registers
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // address driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= '0;
      send_gap      <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        pending_results.push_back(predict_lookup(s_axis_tdata));
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (send_gap != 0) begin
          s_axis_tvalid <= 1'b0;
          send_gap      <= send_gap - 1;
        end else if (addr_queue.size() != 0) begin
          s_axis_tdata  <= addr_queue.pop_front();
          s_axis_tvalid <= 1'b1;
          send_gap      <= no_idle ? 0 : idle_len();
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    lookup_result_t got, want;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[OUT_BITS-1:0];
        if (pending_results.size() == 0) begin
          report_mismatch("result word with none pending, access_total",
                          got.access_total, '0);
        end else begin
          want = pending_results.pop_front();
          if (got.hit !== want.hit)
            report_mismatch("hit", ADDR_W'(got.hit), ADDR_W'(want.hit));
          if (got.way !== want.way)
            report_mismatch("way", ADDR_W'(got.way), ADDR_W'(want.way));
          if (got.fill_address !== want.fill_address)
            report_mismatch("fill_address", got.fill_address, want.fill_address);
          if (got.access_total !== want.access_total)
            report_mismatch("access_total", got.access_total, want.access_total);
          if (got.miss_total !== want.miss_total)
            report_mismatch("miss_total", got.miss_total, want.miss_total);
        end
      end
      if (stall_left != 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= stall_left - 1;
      end else if (!no_idle && $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left    <= idle_len();
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == TIMEOUT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [19:0] hot_tag [6];
    logic [11:0] hot_low [4];
    int unsigned ph, n, s, r;
    for (s = 0; s < SETS; s++) begin
      for (r = 0; r < WAYS; r++) begin
        line_vld[s][r] = 1'b0;
        rank_way[s][r] = r[1:0];
      end
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset geometry: fill set 0 past its four ways, re-hit, evict the LRU line
    addr_queue = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0003, 32'h0000_0100,
                   32'h0000_0200, 32'h0000_0300, 32'h0000_0000, 32'h0000_0400,
                   32'h0000_0100, 32'hFFFF_FFFC};
    wait_idle();

    // write to a missing register, then shrink to one set, byte blocks,
    // direct-mapped; existing lines are reread under the new split
    cfg_write(CFG_NO_REG, 3'd5);
    cfg_write(CFG_OFFSET_BITS, 3'd0);
    cfg_write(CFG_INDEX_BITS, 3'd0);
    cfg_write(CFG_WAYS_IN_USE, 3'd1);
    addr_queue = '{32'h1234_5678, 32'h1234_5678, 32'h8000_0000, 32'h1234_5678,
                   32'h0000_0000};
    wait_idle();

    // oversized offset, index and ways clamp to their maxima
    cfg_write(CFG_OFFSET_BITS, 3'd7);
    cfg_write(CFG_INDEX_BITS, 3'd7);
    cfg_write(CFG_WAYS_IN_USE, 3'd7);
    addr_queue = '{32'hFFFF_FFFF, 32'h0000_003F, 32'hFFFF_F000, 32'h7FFF_FFFF,
                   32'hFFFF_FFC0};
    wait_idle();

    // zero ways in use acts as one
    cfg_write(CFG_OFFSET_BITS, 3'd6);
    cfg_write(CFG_INDEX_BITS, 3'd3);
    cfg_write(CFG_WAYS_IN_USE, 3'd0);
    addr_queue = '{32'h0000_0000, 32'h0000_0040, 32'h0000_1000, 32'h0000_0000};
    wait_idle();

    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      no_idle = (ph % 3 == 1);
      if ($urandom_range(3) == 0) cfg_write(CFG_NO_REG, 3'($urandom_range(7)));
      cfg_write(CFG_OFFSET_BITS, 3'($urandom_range(7)));
      cfg_write(CFG_INDEX_BITS, 3'($urandom_range(7)));
      cfg_write(CFG_WAYS_IN_USE, 3'($urandom_range(7)));
      // a few sets shared by more tags than ways: hits, fills and evictions
      foreach (hot_tag[i]) hot_tag[i] = 20'($urandom);
      foreach (hot_low[i]) hot_low[i] = 12'($urandom);
      for (n = 0; n < PHASE_WORDS; n++) begin
        if ($urandom_range(3) != 0)
          addr_queue.push_back({hot_tag[$urandom_range(5)],
                                hot_low[$urandom_range(3)] ^ 12'($urandom_range(3))});
        else
          addr_queue.push_back($urandom);
      end
      wait_idle();
    end

    no_idle = 1'b0;
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
